// File: src/hrsl_pkg.sv
// shared types, codes and helpers for the hash ring successor lookup
package hrsl_pkg;

	localparam int RING_DEPTH_DEF = 1024;

	// fan-in of one node of the match reduction tree
	localparam int TREE_FAN_LG = 5;
	localparam int TREE_FAN    = 1 << TREE_FAN_LG;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic        op;
		logic [31:0] point;
		logic [31:0] server_ip;
		logic [15:0] server_port;
		logic [31:0] key_hash;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_ip;
		logic [15:0] found_port;
		logic [10:0] point_count;
	} result_t;

	// one ring point held in a cell
	typedef struct packed {
		logic [31:0] point;
		logic [31:0] ip;
		logic [15:0] port;
	} entry_t;

	// hit flag with the server of the hit cell, zero when no hit
	typedef struct packed {
		logic        hit;
		logic [31:0] ip;
		logic [15:0] port;
	} match_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic        ins_en;
		logic [31:0] point;
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] key;
	} cell_ctl_t;

	// register levels of the reduction tree over n leaves
	function automatic int tree_levels(input int n);
		int rem;
		int lv;
		rem = n;
		lv  = 1;
		for (int k = 0; k < 8; k++) begin
			if (rem > TREE_FAN) begin
				rem = (rem + TREE_FAN - 1) >> TREE_FAN_LG;
				lv  = lv + 1;
			end
		end
		return lv;
	endfunction

endpackage

// File: src/hrsl_cell.sv
// one ring cell: holds a point, compares against the broadcast and shifts on insert
module hrsl_cell import hrsl_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 11
) (
	input  logic             clk,
	input  logic [CNT_W-1:0] cnt,
	input  cell_ctl_t        ctl,
	input  entry_t           prev_ent,
	input  logic             prev_gt,
	input  logic             prev_ge,
	output entry_t           ent,
	output logic             gt,
	output logic             ge,
	output match_t           hit
);

	entry_t     ent_q;
	logic       valid;
	logic       room;
	logic       take_new;
	logic       is_hit;

	assign valid = CNT_W'(IDX) < cnt;
	assign room  = CNT_W'(IDX) <= cnt;

	// strictly greater for insert, not below for lookup
	assign gt = valid && (ent_q.point > ctl.point);
	assign ge = valid && (ent_q.point >= ctl.key);

	// new point lands in the first cell above it, or at the fill edge
	assign take_new = room && !prev_gt && (gt || !valid);
	assign is_hit   = ge && !prev_ge;

	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (prev_gt) begin
				ent_q <= prev_ent;
			end else if (take_new) begin
				ent_q <= '{point: ctl.point, ip: ctl.ip, port: ctl.port};
			end
		end
	end

	assign ent = ent_q;
	assign hit = is_hit ? match_t'{hit: 1'b1, ip: ent_q.ip, port: ent_q.port} : match_t'('0);

endmodule

// File: src/hrsl_chain.sv
// row of ring cells kept sorted by point, each cell linked to its lower neighbor
module hrsl_chain import hrsl_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
	input  logic             clk,
	input  logic [CNT_W-1:0] cnt,
	input  cell_ctl_t        ctl,
	output match_t           hit [RING_DEPTH],
	output entry_t           head
);

	entry_t ent [RING_DEPTH];
	logic   gt  [RING_DEPTH];
	logic   ge  [RING_DEPTH];

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			hrsl_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
				.clk      (clk),
				.cnt      (cnt),
				.ctl      (ctl),
				.prev_ent ('0),
				.prev_gt  (1'b0),
				.prev_ge  (1'b0),
				.ent      (ent[i]),
				.gt       (gt[i]),
				.ge       (ge[i]),
				.hit      (hit[i])
			);
		end else begin : g_rest
			hrsl_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
				.clk      (clk),
				.cnt      (cnt),
				.ctl      (ctl),
				.prev_ent (ent[i-1]),
				.prev_gt  (gt[i-1]),
				.prev_ge  (ge[i-1]),
				.ent      (ent[i]),
				.gt       (gt[i]),
				.ge       (ge[i]),
				.hit      (hit[i])
			);
		end
	end

	// smallest point, used when a lookup wraps around
	assign head = ent[0];

endmodule

// File: src/hrsl_or_tree.sv
// registered or-reduction of one-hot cell hits, one level per register
module hrsl_or_tree import hrsl_pkg::*; #(
	parameter int N_IN = RING_DEPTH_DEF
) (
	input  logic   clk,
	input  match_t leaf [N_IN],
	output match_t root
);

	localparam int NODES = (N_IN + TREE_FAN - 1) / TREE_FAN;

	match_t node_s1 [NODES];

	for (genvar g = 0; g < NODES; g++) begin : g_node
		localparam int LO  = g * TREE_FAN;
		localparam int CNT = (N_IN - LO < TREE_FAN) ? (N_IN - LO) : TREE_FAN;
		match_t acc;

		always_comb begin
			acc = '0;
			for (int k = 0; k < CNT; k++) begin
				acc = match_t'(acc | leaf[LO + k]);
			end
		end

		always_ff @(posedge clk) begin
			node_s1[g] <= acc;
		end
	end

	if (NODES == 1) begin : g_root
		assign root = node_s1[0];
	end else begin : g_up
		hrsl_or_tree #(.N_IN(NODES)) u_next (
			.clk  (clk),
			.leaf (node_s1),
			.root (root)
		);
	end

endmodule

// File: src/hash_ring_successor_lookup_core.sv
// top level of the hash ring successor lookup: sequencer, cell row and hit tree
//
// usage
//  - one command channel: request is taken on a rising edge with start high and
//    busy low; request.op selects insert (point, server_ip, server_port) or
//    lookup (key_hash)
//  - one result per command: result is on the port for one cycle with done high;
//    the receiver cannot stall, so it must take every transfer as it comes
//  - insert: the whole row of cells compares and shifts at once in the compare
//    state; a new command is taken only once busy has fallen again
//  - lookup: a compare state, then the hits climb a registered or-tree of
//    fan-in 32 with L register levels, L the tree depth (L = 2 at 1024 points);
//    busy stays high until the last level is through
//  - equal points: an inserted point goes after existing equal ones; a lookup
//    returns the first point not below the hash, wrapping to the smallest
//  - full ring on insert gives status full and leaves the ring as it is; a
//    lookup on an empty ring gives status empty
//  - reset empties the ring at once (count to zero); the cells need no clearing
//    pass since only cells below the count take part in any compare
module hash_ring_successor_lookup_core import hrsl_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int LEVELS = tree_levels(RING_DEPTH);
	localparam int LVL_W  = $clog2(LEVELS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t           state_q;
	request_t         req_q;
	logic [CNT_W-1:0] count_q;
	logic [LVL_W-1:0] lvl_q;
	logic             done_q;
	result_t          rsp_q;

	logic       accept;
	logic       full;
	logic       empty;
	logic       finish;
	cell_ctl_t  ctl;
	match_t     hit [RING_DEPTH];
	entry_t     head;
	match_t     root;
	result_t    rsp_d;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(RING_DEPTH));
	assign empty  = (count_q == '0);

	// insert finishes in its compare cycle, lookup once the tree has drained
	assign finish = ((state_q == ST_EXEC) && (req_q.op == OP_INSERT)) ||
	                ((state_q == ST_WAIT) && (lvl_q == LVL_W'(LEVELS)));

	// broadcast to the cells; the write only happens in the insert cycle
	assign ctl = '{
		ins_en: (state_q == ST_EXEC) && (req_q.op == OP_INSERT) && !full,
		point:  req_q.point,
		ip:     req_q.server_ip,
		port:   req_q.server_port,
		key:    req_q.key_hash
	};

	hrsl_chain #(.RING_DEPTH(RING_DEPTH), .CNT_W(CNT_W)) u_chain (
		.clk  (clk),
		.cnt  (count_q),
		.ctl  (ctl),
		.hit  (hit),
		.head (head)
	);

	hrsl_or_tree #(.N_IN(RING_DEPTH)) u_tree (
		.clk  (clk),
		.leaf (hit),
		.root (root)
	);

	// response for the command that finishes this cycle
	always_comb begin
		rsp_d = '0;
		if (req_q.op == OP_INSERT) begin
			if (full) begin
				rsp_d.status      = STATUS_FULL;
				rsp_d.point_count = 11'(count_q);
			end else begin
				rsp_d.status      = STATUS_OK;
				rsp_d.point_count = 11'(count_q + 1'b1);
			end
		end else begin
			rsp_d.point_count = 11'(count_q);
			if (empty) begin
				rsp_d.status = STATUS_EMPTY;
			end else if (root.hit) begin
				rsp_d.status     = STATUS_OK;
				rsp_d.found_ip   = root.ip;
				rsp_d.found_port = root.port;
			end else begin
				// hash above every point: wrap to the smallest
				rsp_d.status     = STATUS_OK;
				rsp_d.found_ip   = head.ip;
				rsp_d.found_port = head.port;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (req_q.op == OP_INSERT) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT;
						lvl_q   <= LVL_W'(1);
					end
				end
				ST_WAIT: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ring fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins_en) begin
			count_q <= count_q + 1'b1;
		end
	end

	// command and response holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RING_DEPTH))
		else $error("ring count above depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result transfer while a command is still at work");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EXEC) && (req_q.op == OP_INSERT) && full) |=>
		(count_q == $past(count_q)))
		else $error("insert into full ring changed the count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (rsp_q.status == STATUS_FULL)) |-> full)
		else $error("full status with room left");
`endif

endmodule
